// ===== design/regex_char_class_scanner_assert.svh =====
// Assertion macros used by the checker file.
`ifndef REGEX_CHAR_CLASS_SCANNER_ASSERT_SVH
`define REGEX_CHAR_CLASS_SCANNER_ASSERT_SVH

// same-cycle implication
`define RCCS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("rccs: implication check failed");

// next-cycle implication
`define RCCS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("rccs: next-cycle check failed");

`endif

// ===== design/rccs_pkg.sv =====
`default_nettype none

package rccs_pkg;

  localparam int unsigned MaxClassLenDef = 256;

  localparam logic [7:0] ChOpen   = 8'h5B;
  localparam logic [7:0] ChClose  = 8'h5D;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChPrintLo = 8'h20;
  localparam logic [7:0] ChPrintHi = 8'h7E;

  localparam int unsigned MinPlainLen = 3;
  localparam int unsigned MinNegLen   = 4;

  typedef enum logic [1:0] {
    PhOpen,
    PhFirst,
    PhBody
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       neg;
    logic [1:0] fill;
    logic [7:0] items;
    logic       err;
  } ctl_t;

  typedef struct packed {
    logic       valid_res;
    logic       negated;
    logic [7:0] item_count;
    logic [8:0] bracket_len;
  } res_t;

  function automatic logic lone_ok(input logic [7:0] b);
    lone_ok = (b inside {[ChPrintLo:ChPrintHi]}) && (b != ChBslash) && (b != ChOpen);
  endfunction

endpackage

`default_nettype wire

// ===== design/regex_char_class_scanner.sv =====
// Channel | Signals                                         | Direction
// in      | in_valid_i, in_stall_o, char_byte_i, last_i     | byte stream in
// out     | out_valid_o, out_stall_i, valid_res_o,          | one result per scan
//         | negated_o, item_count_o, bracket_len_o          |
// One byte per cycle sustained unless out_stall_i holds a waiting result; a result
// is valid once its closing byte has passed the input and result registers.
// Bytes pass an input register, then the scan state and result register update.
// Reset clears the scan state and both valid flags; the next byte starts a new scan.
// in_stall_o rises only while a result waits and out_stall_i holds it.
`default_nettype none

module regex_char_class_scanner import rccs_pkg::*; #(
  parameter int unsigned MAX_CLASS_LENGTH = MaxClassLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       valid_res_o,
  output logic       negated_o,
  output logic [7:0] item_count_o,
  output logic [8:0] bracket_len_o
);

  localparam int unsigned PosW = $clog2(MAX_CLASS_LENGTH);

  logic            in_v_q, in_v_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  ctl_t            ctl_q, ctl_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      p0_q, p0_d, p1_q, p1_d;
  logic            out_v_q, out_v_d;
  res_t            res_q, res_d;
  logic            emit;
  logic            advance;
  logic            in_take;

  rccs_step #(
    .MAX_CLASS_LENGTH(MAX_CLASS_LENGTH)
  ) u_step (
    .ctl_i (ctl_q),
    .pos_i (pos_q),
    .p0_i  (p0_q),
    .p1_i  (p1_q),
    .b_i   (in_byte_q),
    .last_i(in_last_q),
    .ctl_o (ctl_d),
    .pos_o (pos_d),
    .p0_o  (p0_d),
    .p1_o  (p1_d),
    .emit_o(emit),
    .res_o (res_d)
  );

  assign advance    = in_v_q && (!emit || !out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_v_d = in_v_q;
    if (in_take) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (advance && emit) begin
      out_v_d = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      ctl_q   <= '{phase: PhOpen, neg: 1'b0, fill: 2'd0, items: 8'd0, err: 1'b0};
      pos_q   <= '0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (advance) begin
        ctl_q <= ctl_d;
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= char_byte_i;
      in_last_q <= last_i;
    end
    if (advance) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign valid_res_o   = res_q.valid_res;
  assign negated_o     = res_q.negated;
  assign item_count_o  = res_q.item_count;
  assign bracket_len_o = res_q.bracket_len;

endmodule

`default_nettype wire

// ===== design/rccs_step.sv =====
`default_nettype none

module rccs_step import rccs_pkg::*; #(
  parameter int unsigned MAX_CLASS_LENGTH = MaxClassLenDef,
  localparam int unsigned PosW = $clog2(MAX_CLASS_LENGTH),
  localparam int unsigned LenW = PosW + 1
) (
  input  ctl_t            ctl_i,
  input  logic [PosW-1:0] pos_i,
  input  logic [7:0]      p0_i,
  input  logic [7:0]      p1_i,
  input  logic [7:0]      b_i,
  input  logic            last_i,
  output ctl_t            ctl_o,
  output logic [PosW-1:0] pos_o,
  output logic [7:0]      p0_o,
  output logic [7:0]      p1_o,
  output logic            emit_o,
  output res_t            res_o
);

  logic [LenW-1:0] pos_inc;
  logic [LenW-1:0] need;
  logic [LenW+8:0] len_ext;
  logic [1:0]      inc;
  logic            err_add;
  logic            close;
  logic            ok;
  logic [8:0]      sum;

  always_comb begin
    ctl_o   = ctl_i;
    pos_o   = pos_i;
    p0_o    = p0_i;
    p1_o    = p1_i;
    inc     = 2'd0;
    err_add = 1'b0;
    emit_o  = 1'b0;
    close   = 1'b0;
    pos_inc = {1'b0, pos_i} + LenW'(1);
    need    = ctl_i.neg ? LenW'(MinNegLen) : LenW'(MinPlainLen);
    len_ext = {9'b0, pos_inc};

    case (ctl_i.phase)
      PhOpen: begin
        if (b_i != ChOpen) begin
          emit_o = 1'b1;
        end else begin
          ctl_o.phase = PhFirst;
          pos_o       = PosW'(1);
          if (last_i) emit_o = 1'b1;
        end
      end
      default: begin
        if (b_i == ChClose) begin
          // flush the window
          case (ctl_i.fill)
            2'd2: begin
              if (p0_i == ChBslash) begin
                inc = 2'd1;
              end else begin
                inc     = 2'd2;
                err_add = !lone_ok(p0_i) || !lone_ok(p1_i);
              end
            end
            2'd1: begin
              inc     = 2'd1;
              err_add = !lone_ok(p0_i);
            end
            default: ;
          endcase
          emit_o = 1'b1;
          close  = 1'b1;
        end else begin
          if (ctl_i.phase == PhFirst && b_i == ChCaret) begin
            ctl_o.neg = 1'b1;
          end else begin
            case (ctl_i.fill)
              2'd0: begin
                p0_o       = b_i;
                ctl_o.fill = 2'd1;
              end
              2'd1: begin
                p1_o       = b_i;
                ctl_o.fill = 2'd2;
              end
              default: begin
                if (p1_i == ChDash) begin
                  inc        = 2'd1;
                  err_add    = !($signed(p0_i) <= $signed(b_i));
                  ctl_o.fill = 2'd0;
                end else if (p0_i == ChBslash) begin
                  inc        = 2'd1;
                  p0_o       = b_i;
                  ctl_o.fill = 2'd1;
                end else begin
                  inc        = 2'd1;
                  err_add    = !lone_ok(p0_i);
                  p0_o       = p1_i;
                  p1_o       = b_i;
                  ctl_o.fill = 2'd2;
                end
              end
            endcase
          end
          ctl_o.phase = PhBody;
          pos_o       = pos_inc[PosW-1:0];
          if (last_i || pos_inc >= LenW'(MAX_CLASS_LENGTH)) emit_o = 1'b1;
        end
      end
    endcase

    sum         = {1'b0, ctl_i.items} + 9'(inc);
    ctl_o.items = sum[8] ? 8'hFF : sum[7:0];
    ctl_o.err   = ctl_i.err | err_add;
    ok          = close && !ctl_o.err && (pos_inc >= need);

    res_o.valid_res   = ok;
    res_o.negated     = ok & ctl_i.neg;
    res_o.item_count  = ok ? ctl_o.items : 8'd0;
    res_o.bracket_len = ok ? len_ext[8:0] : 9'd0;

    if (emit_o) begin
      ctl_o = '{phase: PhOpen, neg: 1'b0, fill: 2'd0, items: 8'd0, err: 1'b0};
      pos_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/rccs_checker.sv =====
`default_nettype none

`include "regex_char_class_scanner_assert.svh"

module rccs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_byte_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       valid_res_o,
  input logic       negated_o,
  input logic [7:0] item_count_o,
  input logic [8:0] bracket_len_o
);

  `RCCS_ASSERT_IMP(a_invalid_zero, out_valid_o && !valid_res_o,
    !negated_o && item_count_o == 8'd0 && bracket_len_o == 9'd0)

  `RCCS_ASSERT_IMP(a_valid_has_item, out_valid_o && valid_res_o, item_count_o != 8'd0)

  `RCCS_ASSERT_IMP(a_stall_only_backpressure, in_stall_o, out_valid_o && out_stall_i)

  `RCCS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(valid_res_o) && $stable(negated_o) &&
    $stable(item_count_o) && $stable(bracket_len_o))

  `RCCS_ASSERT_NXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(char_byte_i) && $stable(last_i))

endmodule

bind regex_char_class_scanner rccs_checker u_rccs_checker (.*);

`default_nettype wire
